// ===== sv/point_rotate_project_defines.svh =====
// Assertion macros shared by the point rotate/project RTL.
// Needs nothing; the asserting modules take it by include.
`ifndef POINT_ROTATE_PROJECT_DEFINES_SVH
`define POINT_ROTATE_PROJECT_DEFINES_SVH
`ifndef SYNTHESIS
`define PRT_ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("point_rotate_project assertion failed");
`define PRT_ASSERT(lbl, prop) `PRT_ASSERT_CLK(lbl, clk_i, !rst_ni, prop)
`else
`define PRT_ASSERT_CLK(lbl, clk, rst, prop)
`define PRT_ASSERT(lbl, prop)
`endif
`endif

// ===== sv/prt_pkg.sv =====
// Package for the point rotate/project block: widths, register indexes,
// item and coefficient types. Depends on nothing.
package prt_pkg;

  localparam int COORD_W         = 32;
  localparam int COEF_W          = 16;
  localparam int CFG_IDX_W       = 8;
  localparam int COEF_FRAC_BITS  = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_COS_YAW   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_YAW   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_PITCH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_PITCH = 8'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_yaw;
    logic signed [COEF_W-1:0] sin_yaw;
    logic signed [COEF_W-1:0] cos_pitch;
    logic signed [COEF_W-1:0] sin_pitch;
  } coef_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rot_x;
    logic signed [COORD_W-1:0] rot_y;
    logic signed [COORD_W-1:0] rot_z;
    logic signed [COORD_W-1:0] proj_x;
    logic signed [COORD_W-1:0] proj_y;
    logic                      overflow;
  } out_item_t;

endpackage

// ===== sv/prt_cfg_regs.sv =====
// Coefficient register file: cos/sin of yaw and pitch in signed fixed point.
// Depends on prt_pkg.
module prt_cfg_regs #(
  parameter int FRAC = prt_pkg::COEF_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [prt_pkg::COEF_W-1:0]      cfg_data_i,
  output prt_pkg::coef_t                  coef_o
);
  import prt_pkg::*;

  localparam logic signed [COEF_W-1:0] ONE = COEF_W'(64'd1 << FRAC);

  coef_t coef_q, coef_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COS_YAW:   coef_d.cos_yaw   = cfg_data_i;
        CFG_SIN_YAW:   coef_d.sin_yaw   = cfg_data_i;
        CFG_COS_PITCH: coef_d.cos_pitch = cfg_data_i;
        CFG_SIN_PITCH: coef_d.sin_pitch = cfg_data_i;
        default:       coef_d = coef_q;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.cos_yaw   <= ONE;
      coef_q.sin_yaw   <= '0;
      coef_q.cos_pitch <= ONE;
      coef_q.sin_pitch <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== sv/prt_rot_stage.sv =====
// Plane rotation: u = a*c - b*s, v = a*s + b*c, each sum shifted
// right by FRAC. Stage 1 multiplies, stage 2 adds and shifts. Uses prt_pkg.
module prt_rot_stage #(
  parameter int A_W    = prt_pkg::COORD_W,
  parameter int SIDE_W = prt_pkg::COORD_W,
  parameter int FRAC   = prt_pkg::COEF_FRAC_BITS,
  localparam int AB_W  = (A_W > prt_pkg::COORD_W) ? A_W : prt_pkg::COORD_W,
  localparam int OUT_W = AB_W + prt_pkg::COEF_W + 1 - FRAC
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [A_W-1:0]                a_i,
  input  logic signed [prt_pkg::COORD_W-1:0]   b_i,
  input  logic signed [prt_pkg::COEF_W-1:0]    c_i,
  input  logic signed [prt_pkg::COEF_W-1:0]    s_i,
  input  logic        [SIDE_W-1:0]             side_i,
  output logic                                 valid_o,
  output logic signed [OUT_W-1:0]              u_o,
  output logic signed [OUT_W-1:0]              v_o,
  output logic        [SIDE_W-1:0]             side_o
);
  import prt_pkg::*;

  localparam int PROD_W = AB_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;

  logic                     v1_q, v2_q;
  logic signed [PROD_W-1:0] pac_q, pbs_q, pas_q, pbc_q;
  logic signed [PROD_W-1:0] pac_d, pbs_d, pas_d, pbc_d;
  logic        [SIDE_W-1:0] side1_q, side2_q;
  logic signed [SUM_W-1:0]  sum_u, sum_v;
  logic signed [OUT_W-1:0]  u_q, v_q, u_d, v_d;

  assign pac_d = PROD_W'(a_i) * PROD_W'(c_i);
  assign pbs_d = PROD_W'(b_i) * PROD_W'(s_i);
  assign pas_d = PROD_W'(a_i) * PROD_W'(s_i);
  assign pbc_d = PROD_W'(b_i) * PROD_W'(c_i);

  assign sum_u = SUM_W'(pac_q) - SUM_W'(pbs_q);
  assign sum_v = SUM_W'(pas_q) + SUM_W'(pbc_q);
  // arithmetic shift rounds toward minus infinity
  assign u_d   = OUT_W'(sum_u >>> FRAC);
  assign v_d   = OUT_W'(sum_v >>> FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pac_q   <= pac_d;
    pbs_q   <= pbs_d;
    pas_q   <= pas_d;
    pbc_q   <= pbc_d;
    side1_q <= side_i;
    u_q     <= u_d;
    v_q     <= v_d;
    side2_q <= side1_q;
  end

  assign valid_o = v2_q;
  assign u_o     = u_q;
  assign v_o     = v_q;
  assign side_o  = side2_q;

endmodule

// ===== sv/prt_project.sv =====
// Saturation of the rotated point and oblique projection, two stages.
// Uses prt_pkg and the assertion macros of point_rotate_project_defines.svh.
module prt_project #(
  parameter int X_W = prt_pkg::COORD_W,
  parameter int Y_W = prt_pkg::COORD_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [X_W-1:0]       x_i,
  input  logic signed [Y_W-1:0]       y_i,
  input  logic signed [Y_W-1:0]       z_i,
  output logic                        valid_o,
  output prt_pkg::out_item_t          result_o
);
  import prt_pkg::*;
  `include "point_rotate_project_defines.svh"

  localparam int XY_W = (X_W > Y_W) ? X_W : Y_W;
  localparam int CW   = (XY_W > COORD_W + 1) ? XY_W : COORD_W + 1;
  localparam logic signed [CW-1:0] SAT_HI = CW'(64'sd2147483647);
  localparam logic signed [CW-1:0] SAT_LO = CW'(-64'sd2147483648);
  localparam logic signed [COORD_W-1:0] HI32 = COORD_W'(SAT_HI);
  localparam logic signed [COORD_W-1:0] LO32 = COORD_W'(SAT_LO);

  function automatic logic sat_hit(input logic signed [CW-1:0] v);
    return (v > SAT_HI) || (v < SAT_LO);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_val(input logic signed [CW-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = HI32;
    end else if (v < SAT_LO) begin
      r = LO32;
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

  // stage A: clamp the rotated point
  logic                       sa_valid_q;
  logic signed [COORD_W-1:0]  sa_rx_q, sa_ry_q, sa_rz_q;
  logic signed [CW-1:0]       xe, ye, ze;
  logic [2:0]                 sa_ovf_q, sa_ovf_d;

  assign xe = CW'(x_i);
  assign ye = CW'(y_i);
  assign ze = CW'(z_i);
  assign sa_ovf_d = {sat_hit(ze), sat_hit(ye), sat_hit(xe)};

  // stage B: project from the clamped values
  logic signed [COORD_W-1:0]  half;
  logic signed [CW-1:0]       px_sum, py_sum;
  logic                       out_valid_q;
  out_item_t                  out_q, out_d;

  assign half   = sa_rx_q >>> 1;
  assign px_sum = CW'(half) + CW'(sa_ry_q);
  assign py_sum = CW'(half) + CW'(sa_rz_q);

  always_comb begin
    out_d.rot_x    = sa_rx_q;
    out_d.rot_y    = sa_ry_q;
    out_d.rot_z    = sa_rz_q;
    out_d.proj_x   = sat_val(px_sum);
    out_d.proj_y   = sat_val(py_sum);
    out_d.overflow = (|sa_ovf_q) | sat_hit(px_sum) | sat_hit(py_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sa_valid_q  <= valid_i;
      out_valid_q <= sa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_rx_q  <= sat_val(xe);
    sa_ry_q  <= sat_val(ye);
    sa_rz_q  <= sat_val(ze);
    sa_ovf_q <= sa_ovf_d;
    out_q    <= out_d;
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_q;

  `PRT_ASSERT(a_clamp_x_at_rail, sa_valid_q && sa_ovf_q[0] |-> (sa_rx_q == HI32 || sa_rx_q == LO32))
  `PRT_ASSERT(a_ovf_carries, sa_valid_q && (|sa_ovf_q) |=> out_q.overflow)

endmodule

// ===== sv/point_rotate_project.sv =====
// Top level of the point rotate/project block: config registers, yaw and
// pitch rotation stages, clamp and projection. Uses prt_pkg and the macros.
//
// Usage:
//  - Input: drive in_i with a Q16.16 point and pulse start. The item is taken
//    at each edge with start high and busy low; busy stays low, so a point
//    can enter every cycle.
//  - Output: done_o is high for one cycle with result_o holding the rotated
//    point, its oblique projection and the overflow flag. The receiver has
//    no stall; results leave in input order.
//  - Pipeline: an accepted item passes the yaw stage, the pitch stage, then
//    clamp and projection. Throughput: one item per cycle, set by the six
//    register stages each holding one item.
//  - Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 cos_yaw, 1 sin_yaw,
//    2 cos_pitch, 3 sin_pitch) and cfg_data_i; other indexes are dropped.
//    cfg_ready_o is always high. Write only while no item is in flight.
//  - Reset: rst_ni low clears all valid bits and sets the coefficients to
//    the identity rotation (cos = 1.0, sin = 0).
module point_rotate_project #(
  parameter int COEF_FRAC_BITS = prt_pkg::COEF_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  prt_pkg::in_item_t               in_i,
  output logic                            done_o,
  output prt_pkg::out_item_t              result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [prt_pkg::COEF_W-1:0]      cfg_data_i
);
  import prt_pkg::*;
  `include "point_rotate_project_defines.svh"

  localparam int YAW_W = COORD_W + COEF_W + 1 - COEF_FRAC_BITS;
  localparam int PIT_W = ((YAW_W > COORD_W) ? YAW_W : COORD_W) + COEF_W + 1
                         - COEF_FRAC_BITS;

  coef_t                     coef;
  logic                      in_valid;
  logic                      yaw_valid, pit_valid;
  logic signed [YAW_W-1:0]   x1, y1;
  logic        [COORD_W-1:0] z0;
  logic signed [PIT_W-1:0]   y2, z2;
  logic        [YAW_W-1:0]   x1_d;

  // the pipeline never stalls
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  prt_cfg_regs #(
    .FRAC (COEF_FRAC_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  prt_rot_stage #(
    .A_W    (COORD_W),
    .SIDE_W (COORD_W),
    .FRAC   (COEF_FRAC_BITS)
  ) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .a_i     (in_i.in_x),
    .b_i     (in_i.in_y),
    .c_i     (coef.cos_yaw),
    .s_i     (coef.sin_yaw),
    .side_i  (in_i.in_z),
    .valid_o (yaw_valid),
    .u_o     (x1),
    .v_o     (y1),
    .side_o  (z0)
  );

  prt_rot_stage #(
    .A_W    (YAW_W),
    .SIDE_W (YAW_W),
    .FRAC   (COEF_FRAC_BITS)
  ) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (yaw_valid),
    .a_i     (y1),
    .b_i     ($signed(z0)),
    .c_i     (coef.cos_pitch),
    .s_i     (coef.sin_pitch),
    .side_i  (x1),
    .valid_o (pit_valid),
    .u_o     (y2),
    .v_o     (z2),
    .side_o  (x1_d)
  );

  prt_project #(
    .X_W (YAW_W),
    .Y_W (PIT_W)
  ) u_proj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pit_valid),
    .x_i      ($signed(x1_d)),
    .y_i      (y2),
    .z_i      (z2),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  `PRT_ASSERT(a_done_follows_start, done_o |-> $past(start && !busy, 6))
  `PRT_ASSERT(a_start_gives_done, (start && !busy) |-> ##6 done_o)

endmodule

// ===== tb/sv/tb_point_rotate_project.sv =====
// Testbench for point_rotate_project: streams Q16.16 points through the
// yaw/pitch rotation and oblique projection, checks every result against a
// local predictor. Depends on prt_pkg and the point_rotate_project RTL.

import prt_pkg::*;

// Holds the coefficient copy and the queue of predicted rotated points.
class rotated_point_board;
  coef_t       coefs;
  out_item_t   expected_points[$];
  int          mismatch_count;
  int          results_seen;

  function new();
    coefs.cos_yaw   = COEF_W'(1 << COEF_FRAC_BITS);
    coefs.sin_yaw   = '0;
    coefs.cos_pitch = COEF_W'(1 << COEF_FRAC_BITS);
    coefs.sin_pitch = '0;
    mismatch_count  = 0;
    results_seen    = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    case (idx)
      CFG_COS_YAW:   coefs.cos_yaw   = data;
      CFG_SIN_YAW:   coefs.sin_yaw   = data;
      CFG_COS_PITCH: coefs.cos_pitch = data;
      CFG_SIN_PITCH: coefs.sin_pitch = data;
      default: ;
    endcase
  endfunction

  function logic [COORD_W-1:0] clamp32(longint v, inout logic ovf);
    longint hi;
    longint lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      ovf = 1'b1;
      return hi[COORD_W-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  function out_item_t rotate_and_project(in_item_t p);
    longint    x, y, z, cy, sy, cp, sp;
    longint    x1, y1, y2, z2, half;
    logic      ovf;
    out_item_t r;
    x  = longint'($signed(p.in_x));
    y  = longint'($signed(p.in_y));
    z  = longint'($signed(p.in_z));
    cy = longint'($signed(coefs.cos_yaw));
    sy = longint'($signed(coefs.sin_yaw));
    cp = longint'($signed(coefs.cos_pitch));
    sp = longint'($signed(coefs.sin_pitch));
    ovf = 1'b0;
    // sum both products at full width, then truncate once toward minus infinity
    x1 = (x * cy - y * sy) >>> COEF_FRAC_BITS;
    y1 = (x * sy + y * cy) >>> COEF_FRAC_BITS;
    y2 = (y1 * cp - z * sp) >>> COEF_FRAC_BITS;
    z2 = (y1 * sp + z * cp) >>> COEF_FRAC_BITS;
    r.rot_x = clamp32(x1, ovf);
    r.rot_y = clamp32(y2, ovf);
    r.rot_z = clamp32(z2, ovf);
    // projection works on the clamped values
    half = longint'($signed(r.rot_x)) >>> 1;
    r.proj_x   = clamp32(half + longint'($signed(r.rot_y)), ovf);
    r.proj_y   = clamp32(half + longint'($signed(r.rot_z)), ovf);
    r.overflow = ovf;
    return r;
  endfunction

  function void note_point(in_item_t p);
    expected_points.insert(expected_points.size(), rotate_and_project(p));
  endfunction

  function void compare_field(string name, logic [COORD_W-1:0] exp_v,
                              logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  function void check_point(out_item_t r);
    out_item_t e;
    results_seen++;
    if (expected_points.size() == 0) begin
      $display("%0t: result with no point pending, expected none actual %h", $time, r);
      mismatch_count++;
      return;
    end
    e = expected_points.pop_front();
    compare_field("rot_x", e.rot_x, r.rot_x);
    compare_field("rot_y", e.rot_y, r.rot_y);
    compare_field("rot_z", e.rot_z, r.rot_z);
    compare_field("proj_x", e.proj_x, r.proj_x);
    compare_field("proj_y", e.proj_y, r.proj_y);
    compare_field("overflow", COORD_W'(e.overflow), COORD_W'(r.overflow));
  endfunction

  function bit all_clean();
    if (expected_points.size() != 0)
      $display("%0t: %0d results never arrived", $time, expected_points.size());
    return (mismatch_count == 0) && (expected_points.size() == 0);
  endfunction
endclass

module tb_point_rotate_project;

  localparam int N_DIRECTED       = 12;
  localparam int RANDOM_PHASES    = 10;
  localparam int POINTS_PER_PHASE = 83;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 12;

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] COORD_ONE = 32'h0001_0000;

  localparam logic [COEF_W-1:0] COEF_ONE       = 16'h4000;
  localparam logic [COEF_W-1:0] COEF_MINUS_ONE = 16'hC000;
  localparam logic [COEF_W-1:0] COEF_LOWEST    = 16'h8000;
  localparam logic [COEF_W-1:0] COEF_HIGHEST   = 16'h7FFF;

  localparam int CFG_FIRST_UNUSED = int'(CFG_SIN_PITCH) + 1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_item_t             in_i;
  logic                 done_o;
  out_item_t            result_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [COEF_W-1:0]    cfg_data_i;

  rotated_point_board board = new();
  int points_sent  = 0;
  int quiet_cycles = 0;

  point_rotate_project i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
      1, 2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h7F_FFFF) - 32'h40_0000;
    endcase
  endfunction

  function automatic in_item_t random_point();
    in_item_t p;
    p.in_x = random_coord();
    p.in_y = random_coord();
    p.in_z = random_coord();
    return p;
  endfunction

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 6))
      0: return COEF_ONE;
      1: return COEF_MINUS_ONE;
      2: return COEF_LOWEST;
      3: return COEF_HIGHEST;
      4, 5: return COEF_W'($urandom_range(0, 32768) - 16384);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t directed_point(int k);
    in_item_t p;
    case (k % N_DIRECTED)
      0: p = '{'0, '0, '0};
      1: p = '{COORD_MAX, COORD_MAX, COORD_MAX};
      2: p = '{COORD_MIN, COORD_MIN, COORD_MIN};
      3: p = '{COORD_MAX, COORD_MIN, COORD_MAX};
      4: p = '{COORD_MIN, COORD_MAX, COORD_MIN};
      5: p = '{32'd1, 32'd1, 32'd1};
      6: p = '{'1, '1, '1};
      7: p = '{COORD_ONE, -COORD_ONE, COORD_ONE};
      8: p = '{-32'd3, 32'd5, -32'd7};
      9: p = '{COORD_MAX, '0, COORD_MIN};
      10: p = '{COORD_MIN, '0, COORD_MAX};
      default: p = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0};
    endcase
    return p;
  endfunction

  // Hold valid across back-to-back writes; drop it only for an idle burst.
  task automatic write_coefs(coef_t c, bit idle_on);
    logic [CFG_IDX_W-1:0] idx[5];
    logic [COEF_W-1:0]    val[5];
    int                   n;
    idx[0] = CFG_COS_YAW;   val[0] = c.cos_yaw;
    idx[1] = CFG_SIN_YAW;   val[1] = c.sin_yaw;
    idx[2] = CFG_COS_PITCH; val[2] = c.cos_pitch;
    idx[3] = CFG_SIN_PITCH; val[3] = c.sin_pitch;
    n = 4;
    if ($urandom_range(0, 2) == 0) begin
      idx[4] = CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1));
      val[4] = COEF_W'($urandom);
      n = 5;
    end
    for (int k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (idle_on && k < n - 1 && $urandom_range(0, 3) == 0) begin
        cfg_valid_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_points(int count, bit directed, bit idle_on);
    in_item_t p;
    for (int k = 0; k < count; k++) begin
      p = directed ? directed_point(k) : random_point();
      start <= 1'b1;
      in_i  <= p;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      points_sent++;
      if (idle_on && k < count - 1 && $urandom_range(0, 3) == 0) begin
        // junk on the data lines while start is low must be ignored
        start <= 1'b0;
        in_i  <= random_point();
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
    start <= 1'b0;
  endtask

  task automatic wait_drain();
    while (board.results_seen < points_sent) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (start && !busy) board.note_point(in_i);
      if (done_o) board.check_point(result_o);
      if ((cfg_valid_i && cfg_ready_o) || (start && !busy) || done_o)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    coef_t c;
    bit    idle_on;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    in_i        <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity rotation straight out of reset
    run_points(N_DIRECTED, 1'b1, 1'b0);

    // coefficients at the signed 16-bit extremes, outside the nominal range
    wait_drain();
    c = '{COEF_LOWEST, COEF_HIGHEST, COEF_HIGHEST, COEF_LOWEST};
    write_coefs(c, 1'b0);
    run_points(N_DIRECTED, 1'b1, 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: c = '{COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE};
        1: c = '{COEF_MINUS_ONE, COEF_MINUS_ONE, COEF_MINUS_ONE, COEF_MINUS_ONE};
        2: c = '0;
        default: c = '{random_coef(), random_coef(), random_coef(), random_coef()};
      endcase
      // no idling in the closing phases
      idle_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      wait_drain();
      write_coefs(c, idle_on);
      run_points(POINTS_PER_PHASE, 1'b0, idle_on);
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.all_clean())
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
